### rtl/core/rpd_pkg.sv
// Shared types and constants for the RTP H.264 depacketizer.
// No dependencies; used by every module under rtl/core.
package rpd_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int HDR_FIXED_BYTES  = 12;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int OFS_W            = 19;
    localparam int SIZE_W           = 24;
    localparam int TS_W             = 32;
    localparam int QUEUE_DEPTH      = 8;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CSRC_MASK   = 8'h0F;
    localparam logic [7:0] EXT_FLAG    = 8'h10;
    localparam logic [7:0] MARKER_FLAG = 8'h80;
    localparam logic [7:0] SC_ONE      = 8'h01;
    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    // One queued command: an optional unit close, an optional start code,
    // and an optional payload byte.
    typedef struct packed {
        logic              has_close;
        logic              has_data;
        logic              has_sc;
        logic              sc_long;
        logic [7:0]        data;
        logic [TS_W-1:0]   unit_ts;
        logic [TS_W-1:0]   close_ts;
        logic [SIZE_W-1:0] close_size;
    } t_cmd;

    typedef enum logic [5:0] {
        PH_CLOSE = 6'b000001,
        PH_Z0    = 6'b000010,
        PH_Z1    = 6'b000100,
        PH_Z2    = 6'b001000,
        PH_ONE   = 6'b010000,
        PH_DATA  = 6'b100000
    } t_phase;

endpackage

### rtl/core/rpd_queue.sv
// Short command queue between the parser front and the emitter back.
// Depends on rpd_pkg (t_cmd, queue sizing).
module rpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpd_pkg::t_cmd   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rpd_pkg::t_cmd   o_data
);

    rpd_pkg::t_cmd                 r_mem [rpd_pkg::QUEUE_DEPTH];
    logic [rpd_pkg::QPTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [rpd_pkg::QPTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [rpd_pkg::QCNT_W-1:0]    r_count, n_count;
    logic                          w_push, w_pop;

    assign o_full  = (r_count == rpd_pkg::QCNT_W'(rpd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("command popped from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |->
        (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

### rtl/core/rpd_front.sv
// Parser front: takes input transfers, walks the RTP header, tracks the
// open access unit and pushes one command per item that yields results.
// Depends on rpd_pkg.
module rpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_kind,
    input  logic [7:0]      i_in_byte,
    input  logic            i_packet_end,
    input  logic            i_q_full,
    output logic            o_q_push,
    output rpd_pkg::t_cmd   o_q_data
);

    logic [rpd_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [3:0]                  r_csrc, n_csrc;
    logic                        r_ext, n_ext;
    logic [7:0]                  r_ext_hi, n_ext_hi;
    logic [rpd_pkg::OFS_W-1:0]   r_ofs, n_ofs;
    logic                        r_marker, n_marker;
    logic [rpd_pkg::TS_W-1:0]    r_pkt_ts, n_pkt_ts;
    logic                        r_started, n_started;
    logic                        r_open, n_open;
    logic [rpd_pkg::TS_W-1:0]    r_open_ts, n_open_ts;
    logic [rpd_pkg::SIZE_W-1:0]  r_size, n_size;

    logic                        w_acc;
    logic [rpd_pkg::OFS_W-1:0]   w_pos_x, w_ext_base;
    logic [rpd_pkg::SIZE_W-1:0]  w_base;
    logic [2:0]                  w_inc;
    logic [rpd_pkg::SIZE_W:0]    w_sum;
    logic                        w_close;
    rpd_pkg::t_cmd               w_cmd;
    logic                        w_push;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_pos_x = rpd_pkg::OFS_W'(r_pos);
    assign w_ext_base = rpd_pkg::OFS_W'(rpd_pkg::HDR_FIXED_BYTES)
                      + rpd_pkg::OFS_W'({r_csrc, 2'b00});
    assign w_sum   = {1'b0, w_base} + (rpd_pkg::SIZE_W+1)'(w_inc);

    always_comb begin
        n_pos     = r_pos;
        n_csrc    = r_csrc;
        n_ext     = r_ext;
        n_ext_hi  = r_ext_hi;
        n_ofs     = r_ofs;
        n_marker  = r_marker;
        n_pkt_ts  = r_pkt_ts;
        n_started = r_started;
        n_open    = r_open;
        n_open_ts = r_open_ts;
        n_size    = r_size;
        w_base    = r_size;
        w_inc     = '0;
        w_close   = 1'b0;
        w_push    = 1'b0;
        w_cmd     = '0;

        if (w_acc) begin
            if (i_kind) begin
                // flush: close the open unit, drop any partial packet
                if (r_open) begin
                    w_push           = 1'b1;
                    w_cmd.has_close  = 1'b1;
                    w_cmd.close_ts   = r_open_ts;
                    w_cmd.close_size = r_size;
                    n_open           = 1'b0;
                    n_size           = '0;
                end
            end else if (r_pos < rpd_pkg::POS_W'(rpd_pkg::MAX_PACKET_BYTES)) begin
                n_pos = r_pos + 1'b1;
                if (r_pos == '0) begin
                    n_csrc = 4'(i_in_byte & rpd_pkg::CSRC_MASK);
                    n_ext  = |(i_in_byte & rpd_pkg::EXT_FLAG);
                    n_ofs  = rpd_pkg::OFS_W'(rpd_pkg::HDR_FIXED_BYTES)
                           + rpd_pkg::OFS_W'({i_in_byte[3:0], 2'b00})
                           + (n_ext ? rpd_pkg::OFS_W'(4) : '0);
                end else if (r_pos == rpd_pkg::POS_W'(1)) begin
                    n_marker = |(i_in_byte & rpd_pkg::MARKER_FLAG);
                end else if (r_pos >= rpd_pkg::POS_W'(4)
                             && r_pos <= rpd_pkg::POS_W'(7)) begin
                    n_pkt_ts = {r_pkt_ts[rpd_pkg::TS_W-9:0], i_in_byte};
                end else if (w_pos_x >= r_ofs) begin
                    w_push        = 1'b1;
                    w_cmd.has_data = 1'b1;
                    w_cmd.data    = i_in_byte;
                    w_inc         = 3'd1;
                    if (!r_started) begin
                        // first payload byte: maybe close, then start code
                        n_started    = 1'b1;
                        w_close      = r_open && (r_open_ts != r_pkt_ts);
                        w_cmd.has_close  = w_close;
                        w_cmd.close_ts   = r_open_ts;
                        w_cmd.close_size = r_size;
                        w_cmd.has_sc     = 1'b1;
                        w_cmd.sc_long    = r_marker;
                        w_inc            = r_marker ? 3'd5 : 3'd4;
                        if (!r_open || w_close) begin
                            n_open    = 1'b1;
                            n_open_ts = r_pkt_ts;
                            w_base    = '0;
                        end
                    end
                    w_cmd.unit_ts = n_open_ts;
                    n_size = w_sum[rpd_pkg::SIZE_W] ? rpd_pkg::SIZE_SAT
                                                    : w_sum[rpd_pkg::SIZE_W-1:0];
                end else if (r_ext && w_pos_x == w_ext_base + rpd_pkg::OFS_W'(2)) begin
                    n_ext_hi = i_in_byte;
                end else if (r_ext && w_pos_x == w_ext_base + rpd_pkg::OFS_W'(3)) begin
                    n_ofs = r_ofs + rpd_pkg::OFS_W'({r_ext_hi, i_in_byte, 2'b00});
                end
            end

            if (i_kind || i_packet_end) begin
                n_pos     = '0;
                n_csrc    = '0;
                n_ext     = 1'b0;
                n_ext_hi  = '0;
                n_ofs     = rpd_pkg::OFS_W'(rpd_pkg::HDR_FIXED_BYTES);
                n_marker  = 1'b0;
                n_pkt_ts  = '0;
                n_started = 1'b0;
            end
        end
    end

    assign o_q_push = w_push;
    assign o_q_data = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_csrc    <= '0;
            r_ext     <= 1'b0;
            r_ext_hi  <= '0;
            r_ofs     <= rpd_pkg::OFS_W'(rpd_pkg::HDR_FIXED_BYTES);
            r_marker  <= 1'b0;
            r_pkt_ts  <= '0;
            r_started <= 1'b0;
            r_open    <= 1'b0;
            r_open_ts <= '0;
            r_size    <= '0;
        end else begin
            r_pos     <= n_pos;
            r_csrc    <= n_csrc;
            r_ext     <= n_ext;
            r_ext_hi  <= n_ext_hi;
            r_ofs     <= n_ofs;
            r_marker  <= n_marker;
            r_pkt_ts  <= n_pkt_ts;
            r_started <= n_started;
            r_open    <= n_open;
            r_open_ts <= n_open_ts;
            r_size    <= n_size;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= rpd_pkg::POS_W'(rpd_pkg::MAX_PACKET_BYTES))
        else $error("byte position past packet limit");
    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> (r_size == '0))
        else $error("closed unit holds a byte count");
    a_started_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_open)
        else $error("payload started with no open unit");

endmodule

### rtl/core/rpd_back.sv
// Emitter back: expands the queue head into result transfers, one per
// cycle unless stalled, into a registered output stage. Depends on rpd_pkg.
module rpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  rpd_pkg::t_cmd               i_q_data,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_out_kind,
    output logic [7:0]                  o_out_byte,
    output logic [rpd_pkg::TS_W-1:0]    o_unit_timestamp,
    output logic [rpd_pkg::SIZE_W-1:0]  o_unit_size,
    output logic                        o_run_last
);

    rpd_pkg::t_phase              r_phase, n_phase;
    logic                         r_busy, n_busy;
    logic                         r_valid, n_valid;
    logic                         r_kind;
    logic [7:0]                   r_byte;
    logic [rpd_pkg::TS_W-1:0]     r_ts;
    logic [rpd_pkg::SIZE_W-1:0]   r_size;
    logic                         r_last;

    rpd_pkg::t_phase              w_first, w_phase, w_next;
    logic                         w_last, w_adv;
    logic [7:0]                   w_byte;

    assign w_adv = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        if (i_q_data.has_close) begin
            w_first = rpd_pkg::PH_CLOSE;
        end else if (i_q_data.has_sc) begin
            w_first = rpd_pkg::PH_Z0;
        end else begin
            w_first = rpd_pkg::PH_DATA;
        end
        w_phase = r_busy ? r_phase : w_first;

        w_last = 1'b0;
        w_byte = 8'h00;
        unique case (w_phase)
            rpd_pkg::PH_CLOSE: begin
                w_last = !i_q_data.has_data;
                w_next = i_q_data.has_sc ? rpd_pkg::PH_Z0 : rpd_pkg::PH_DATA;
            end
            rpd_pkg::PH_Z0:  w_next = rpd_pkg::PH_Z1;
            rpd_pkg::PH_Z1:  w_next = i_q_data.sc_long ? rpd_pkg::PH_Z2 : rpd_pkg::PH_ONE;
            rpd_pkg::PH_Z2:  w_next = rpd_pkg::PH_ONE;
            rpd_pkg::PH_ONE: begin
                w_byte = rpd_pkg::SC_ONE;
                w_next = rpd_pkg::PH_DATA;
            end
            rpd_pkg::PH_DATA: begin
                w_last = 1'b1;
                w_byte = i_q_data.data;
                w_next = rpd_pkg::PH_DATA;
            end
            default: begin
                w_last = 1'b1;
                w_next = rpd_pkg::PH_DATA;
            end
        endcase

        n_valid = r_valid;
        if (w_adv) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
        n_busy  = r_busy;
        n_phase = r_phase;
        if (w_adv) begin
            n_busy  = !w_last;
            n_phase = w_next;
        end
    end

    assign o_q_pop = w_adv && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_phase <= rpd_pkg::PH_DATA;
        end else begin
            r_valid <= n_valid;
            r_busy  <= n_busy;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kind <= (w_phase == rpd_pkg::PH_CLOSE);
            r_byte <= w_byte;
            r_ts   <= (w_phase == rpd_pkg::PH_CLOSE) ? i_q_data.close_ts
                                                     : i_q_data.unit_ts;
            r_size <= (w_phase == rpd_pkg::PH_CLOSE) ? i_q_data.close_size : '0;
            r_last <= w_last;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_kind       = r_kind;
    assign o_out_byte       = r_byte;
    assign o_unit_timestamp = r_ts;
    assign o_unit_size      = r_size;
    assign o_run_last       = r_last;

    a_busy_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_q_valid)
        else $error("mid-command with empty queue");
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (o_valid && o_run_last))
        else $error("command retired without a last result");
    a_close_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_kind) |-> (o_unit_size == '0))
        else $error("data result carries a unit size");

endmodule

### rtl/core/rtp_h264_depacketizer.sv
// Top level of the RTP H.264 depacketizer: parser front, command queue,
// emitter back. Depends on rpd_pkg, rpd_front, rpd_queue, rpd_back.
//
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_kind, i_in_byte, i_packet_end
// result    out        o_valid / i_ready    o_out_kind, o_out_byte,
//                                           o_unit_timestamp, o_unit_size,
//                                           o_run_last
//
// The front takes one input transfer per cycle while the command queue has
// room; each header or payload byte is parsed in that same cycle.
// The back emits one result transfer per cycle while i_ready lets the output
// register drain: a payload byte yields one transfer, the first payload byte
// of a packet 4 or 5 (start code), plus one more if it closes a unit. The
// 8-entry queue absorbs these bursts.
// Synchronous active-low reset clears all parse, unit and queue state.
// A stalled result holds in the output register; the front keeps taking
// bytes until the queue fills.
module rtp_h264_depacketizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_kind,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_packet_end,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_out_kind,
    output logic [7:0]                  o_out_byte,
    output logic [rpd_pkg::TS_W-1:0]    o_unit_timestamp,
    output logic [rpd_pkg::SIZE_W-1:0]  o_unit_size,
    output logic                        o_run_last
);

    logic           w_push, w_full, w_pop, w_q_valid;
    rpd_pkg::t_cmd  w_push_data, w_head;

    // header parse and unit tracking
    rpd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_in_byte    (i_in_byte),
        .i_packet_end (i_packet_end),
        .i_q_full     (w_full),
        .o_q_push     (w_push),
        .o_q_data     (w_push_data)
    );

    // decouples parse rate from start-code bursts and output stalls
    rpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_head)
    );

    // one result per cycle into the output register, unless the output stalls
    rpd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_data         (w_head),
        .o_q_pop          (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_unit_timestamp (o_unit_timestamp),
        .o_unit_size      (o_unit_size),
        .o_run_last       (o_run_last)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for rtp_h264_depacketizer: directed table, then random RTP traffic.
// Depends on rpd_pkg and the rtp_h264_depacketizer RTL; predicts the access unit stream itself.
module tb;

    // Input kinds and result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;
    localparam logic AU_DATA    = 1'b0;
    localparam logic AU_END     = 1'b1;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 210;

    // One result transfer as seen on the output port
    typedef struct packed {
        logic                       kind;
        logic [7:0]                 data;
        logic [rpd_pkg::TS_W-1:0]   ts;
        logic [rpd_pkg::SIZE_W-1:0] size;
        logic                       last;
    } t_au_result;

    // Directed row: one input transfer, optionally with the count of results
    // and the last result typed in
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       pkt_end;
        logic       pinned;
        logic [2:0] n_res;
        t_au_result last_res;
    } t_stim_row;

    localparam t_au_result NO_RES = '0;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_kind = 1'b0;
    logic [7:0]                 in_byte = 8'h00;
    logic                       in_end = 1'b0;
    logic                       res_ready = 1'b0;
    logic                       o_ready;
    logic                       o_valid;
    logic                       o_out_kind;
    logic [7:0]                 o_out_byte;
    logic [rpd_pkg::TS_W-1:0]   o_unit_timestamp;
    logic [rpd_pkg::SIZE_W-1:0] o_unit_size;
    logic                       o_run_last;

    int  errors = 0;
    int  cycles = 0;
    int  items_sent = 0;
    bit  calm = 1'b0;          // no idling on either side while set
    logic [rpd_pkg::TS_W-1:0] cur_ts = '0;

    t_au_result au_pending [$];    // results still owed by the block
    t_au_result step_out [$];      // results of the item being predicted

    // Predictor state: packet parse
    logic [11:0]                pos_q;
    logic [3:0]                 cc_q;
    logic                       ext_q;
    logic [7:0]                 ext_hi_q;
    logic [rpd_pkg::OFS_W-1:0]  pay_ofs_q;
    logic                       mark_q;
    logic [rpd_pkg::TS_W-1:0]   pkt_ts_q;
    logic                       pay_on_q;
    // Predictor state: open access unit
    logic                       au_open_q;
    logic [rpd_pkg::TS_W-1:0]   au_ts_q;
    logic [rpd_pkg::SIZE_W-1:0] au_size_q;

    t_stim_row dir_rows [0:18];

    rtp_h264_depacketizer dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (o_ready),
        .i_kind           (in_kind),
        .i_in_byte        (in_byte),
        .i_packet_end     (in_end),
        .o_valid          (o_valid),
        .i_ready          (res_ready),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_unit_timestamp (o_unit_timestamp),
        .o_unit_size      (o_unit_size),
        .o_run_last       (o_run_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycles);
    endtask

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void clear_packet();
        pos_q     = '0;
        cc_q      = '0;
        ext_q     = 1'b0;
        ext_hi_q  = '0;
        pay_ofs_q = rpd_pkg::OFS_W'(rpd_pkg::HDR_FIXED_BYTES);
        mark_q    = 1'b0;
        pkt_ts_q  = '0;
        pay_on_q  = 1'b0;
    endfunction

    function automatic void put_result(input logic k, input logic [7:0] b,
                                       input logic [rpd_pkg::TS_W-1:0] ts,
                                       input logic [rpd_pkg::SIZE_W-1:0] sz);
        t_au_result r;
        r.kind = k;
        r.data = b;
        r.ts   = ts;
        r.size = sz;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    // Data byte of the open unit; unit size saturates
    function automatic void put_data(input logic [7:0] b);
        put_result(AU_DATA, b, au_ts_q, '0);
        if (au_size_q != rpd_pkg::SIZE_SAT)
            au_size_q = au_size_q + 1'b1;
    endfunction

    function automatic void close_au();
        put_result(AU_END, 8'h00, au_ts_q, au_size_q);
        au_open_q = 1'b0;
        au_size_q = '0;
    endfunction

    // Advances the predictor by one accepted input and queues its results
    function automatic int depacketize(input logic k, input logic [7:0] b, input logic l);
        int ext_base;
        int n;
        step_out.delete();
        if (k == KIND_FLUSH) begin
            if (au_open_q)
                close_au();
            clear_packet();
        end else begin
            if (pos_q < rpd_pkg::MAX_PACKET_BYTES) begin
                ext_base = rpd_pkg::HDR_FIXED_BYTES + 4 * int'(cc_q);
                if (pos_q == 0) begin
                    cc_q      = 4'(b & rpd_pkg::CSRC_MASK);
                    ext_q     = (b & rpd_pkg::EXT_FLAG) != 0;
                    pay_ofs_q = rpd_pkg::OFS_W'(rpd_pkg::HDR_FIXED_BYTES
                                + 4 * int'(b & rpd_pkg::CSRC_MASK)
                                + (((b & rpd_pkg::EXT_FLAG) != 0) ? 4 : 0));
                end else if (pos_q == 1) begin
                    mark_q = (b & rpd_pkg::MARKER_FLAG) != 0;
                end else if (pos_q >= 4 && pos_q <= 7) begin
                    pkt_ts_q = {pkt_ts_q[rpd_pkg::TS_W-9:0], b};
                end else if (pos_q >= pay_ofs_q) begin
                    if (!pay_on_q) begin
                        // first payload byte: maybe close, then start code
                        pay_on_q = 1'b1;
                        if (au_open_q && au_ts_q != pkt_ts_q)
                            close_au();
                        if (!au_open_q) begin
                            au_open_q = 1'b1;
                            au_ts_q   = pkt_ts_q;
                            au_size_q = '0;
                        end
                        put_data(8'h00);
                        put_data(8'h00);
                        if (mark_q)
                            put_data(8'h00);
                        put_data(rpd_pkg::SC_ONE);
                    end
                    put_data(b);
                end else if (ext_q && int'(pos_q) == ext_base + 2) begin
                    ext_hi_q = b;
                end else if (ext_q && int'(pos_q) == ext_base + 3) begin
                    pay_ofs_q = rpd_pkg::OFS_W'(int'(pay_ofs_q) + 4 * int'({ext_hi_q, b}));
                end
                pos_q = pos_q + 1'b1;
            end
            if (l)
                clear_packet();
        end
        n = step_out.size();
        if (n > 0)
            step_out[n-1].last = 1'b1;
        foreach (step_out[i])
            au_pending.push_back(step_out[i]);
        return n;
    endfunction

    // ---------------------------------------------------------------
    // Input side: random idle cycles, valid held until the transfer
    // ---------------------------------------------------------------
    task automatic feed_item(input logic k, input logic [7:0] b, input logic l,
                             output int n);
        while (!calm && $urandom_range(99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= k;
        in_byte  <= b;
        in_end   <= l;
        @(posedge clk);
        while (!o_ready)
            @(posedge clk);
        n = depacketize(k, b, l);
        items_sent++;
    endtask

    // Well-formed RTP packet with random content, sometimes cut short or
    // abandoned by a flush
    task automatic send_packet();
        logic [7:0]  pkt [$];
        logic [7:0]  b0;
        logic [3:0]  cc;
        logic        ext;
        logic [15:0] ext_len;
        int          pay_len;
        int          len;
        int          n;
        bit          abort;
        cc  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1));
        ext = ($urandom_range(2) == 0);
        ext_len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2));
        pay_len = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 12);
        if ($urandom_range(99) >= 60)
            cur_ts = $urandom;
        b0 = 8'($urandom);
        b0[4] = ext;
        b0[3:0] = cc;
        pkt.push_back(b0);
        pkt.push_back({1'($urandom), 7'($urandom)});
        repeat (2) pkt.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--)
            pkt.push_back(cur_ts[8*i +: 8]);
        repeat (4 + 4 * int'(cc)) pkt.push_back(8'($urandom));
        if (ext) begin
            repeat (2) pkt.push_back(8'($urandom));
            pkt.push_back(ext_len[15:8]);
            pkt.push_back(ext_len[7:0]);
            if (ext_len <= 3) begin
                repeat (4 * int'(ext_len)) pkt.push_back(8'($urandom));
            end else begin
                // extension reaches past the packet: no payload
                repeat ($urandom_range(8)) pkt.push_back(8'($urandom));
                pay_len = 0;
            end
        end
        repeat (pay_len) pkt.push_back(8'($urandom));
        len   = pkt.size();
        abort = 1'b0;
        if ($urandom_range(99) < 15) begin
            len = $urandom_range(1, pkt.size());
        end else if ($urandom_range(99) < 8) begin
            len   = $urandom_range(1, pkt.size());
            abort = 1'b1;
        end
        for (int i = 0; i < len; i++)
            feed_item(KIND_BYTE, pkt[i], (i == len - 1) && !abort, n);
        if (abort)
            feed_item(KIND_FLUSH, 8'($urandom), 1'($urandom), n);
    endtask

    // ---------------------------------------------------------------
    // Output side: random stalls, every transfer checked in order
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_au_result want;
        if (rst_n && o_valid && res_ready) begin
            if (au_pending.size() == 0) begin
                report_mismatch("result with nothing pending",
                                {23'b0, o_out_kind, o_out_byte}, 0);
            end else begin
                want = au_pending.pop_front();
                if (o_out_kind !== want.kind)
                    report_mismatch("out_kind", 32'(o_out_kind), 32'(want.kind));
                if (o_out_byte !== want.data)
                    report_mismatch("out_byte", 32'(o_out_byte), 32'(want.data));
                if (o_unit_timestamp !== want.ts)
                    report_mismatch("unit_timestamp", o_unit_timestamp, want.ts);
                if (o_unit_size !== want.size)
                    report_mismatch("unit_size", 32'(o_unit_size), 32'(want.size));
                if (o_run_last !== want.last)
                    report_mismatch("run_last", 32'(o_run_last), 32'(want.last));
            end
        end
        res_ready <= calm || ($urandom_range(99) >= 34);
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int n;
        int rnd_base;
        int sel;

        // Directed: flush with nothing open, a short packet, a marked
        // packet with all-ones timestamp and one payload byte, its close,
        // and a flush that finds nothing to close.
        dir_rows = '{
            '{KIND_FLUSH, 8'hFF, 1'b1, 1'b1, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h80, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b1, 1'b1, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h80, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'hFF, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'hFF, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'hFF, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'hFF, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'hFF, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'h00, 1'b0, 1'b0, 3'd0, NO_RES},
            '{KIND_BYTE,  8'hFF, 1'b1, 1'b1, 3'd5,
              '{AU_DATA, 8'hFF, 32'hFFFF_FFFF, 24'd0, 1'b1}},
            '{KIND_FLUSH, 8'h00, 1'b0, 1'b1, 3'd1,
              '{AU_END, 8'h00, 32'hFFFF_FFFF, 24'd5, 1'b1}},
            '{KIND_FLUSH, 8'h00, 1'b0, 1'b1, 3'd0, NO_RES}
        };

        au_open_q = 1'b0;
        au_ts_q   = '0;
        au_size_q = '0;
        clear_packet();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            feed_item(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].pkt_end, n);
            if (dir_rows[i].pinned) begin
                if (n != int'(dir_rows[i].n_res))
                    report_mismatch("result count of directed row", n,
                                    32'(dir_rows[i].n_res));
                // typed result replaces the predicted one
                if (n > 0)
                    au_pending[au_pending.size()-1] = dir_rows[i].last_res;
            end
        end

        // Random: mostly packets, some flushes and loose bytes; a stretch in
        // the middle runs with no idling on either side
        rnd_base = items_sent;
        while (items_sent - rnd_base < RANDOM_ITEMS) begin
            calm = (items_sent - rnd_base >= 80) && (items_sent - rnd_base < 160);
            sel  = $urandom_range(99);
            if (sel < 72) begin
                send_packet();
            end else if (sel < 86) begin
                feed_item(KIND_FLUSH, 8'($urandom), 1'($urandom), n);
            end else begin
                repeat ($urandom_range(1, 4))
                    feed_item(KIND_BYTE, 8'($urandom), 1'($urandom), n);
            end
        end
        calm = 1'b0;
        feed_item(KIND_FLUSH, 8'($urandom), 1'($urandom), n);
        in_valid <= 1'b0;

        while (au_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
